@@ rtl/core/wtpc_pkg.sv @@
package wtpc_pkg;

    // Defaults for top-level parameters
    localparam int WAYPOINT_DEPTH_DEF = 256;
    localparam int CORDIC_STEPS_DEF   = 16;

    // Input opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ODOM = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_REACH_XY  = 3'd0;
    localparam logic [2:0] REG_REACH_Z   = 3'd1;
    localparam logic [2:0] REG_LIM_XY    = 3'd2;
    localparam logic [2:0] REG_LIM_Z     = 3'd3;
    localparam logic [2:0] REG_LIM_YAW   = 3'd4;
    localparam logic [2:0] REG_GAIN_XY   = 3'd5;
    localparam logic [2:0] REG_GAIN_Z    = 3'd6;
    localparam logic [2:0] REG_GAIN_YAW  = 3'd7;

    // Angles, Q16.16 radians
    localparam int ANG_PI      = 205887;
    localparam int ANG_TWO_PI  = 411774;
    localparam int ANG_HALF_PI = 102944;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_VEL  = 2'd1,
        KIND_ADV  = 2'd2,
        KIND_STOP = 2'd3
    } kind_t;

    // Classified item, front to back
    typedef enum logic [1:0] {
        CLS_LOAD,
        CLS_ODOM,
        CLS_TICK
    } item_class_t;

    typedef struct packed {
        item_class_t        cls;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [14:0] heading;
        logic               path_start;
    } item_t;

    typedef struct packed {
        logic [30:0] reach_xy;
        logic [30:0] reach_z;
        logic [30:0] lim_xy;
        logic [30:0] lim_z;
        logic [30:0] lim_yaw;
        logic [15:0] gain_xy;
        logic [15:0] gain_z;
        logic [15:0] gain_yaw;
    } cfg_t;

    // Back-end sequencer states
    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_DIF, ST_DXX, ST_DYY, ST_RR, ST_REACH,
        ST_VX, ST_VY, ST_VZ, ST_VXX, ST_VYY, ST_LL, ST_LIMT,
        ST_SQRT, ST_PX, ST_DIVX, ST_PY, ST_DIVY,
        ST_CINIT, ST_CORD, ST_ERR, ST_WRAP, ST_WR, ST_OUT
    } back_state_t;

    // Rounded Q16.16 arctangent of 2^-i
    function automatic logic [15:0] atan_lut(input logic [4:0] i);
        logic [15:0] a;
        case (i)
            5'd0:    a = 16'd51472;
            5'd1:    a = 16'd30386;
            5'd2:    a = 16'd16055;
            5'd3:    a = 16'd8150;
            5'd4:    a = 16'd4091;
            5'd5:    a = 16'd2047;
            5'd6:    a = 16'd1024;
            5'd7:    a = 16'd512;
            5'd8:    a = 16'd256;
            5'd9:    a = 16'd128;
            5'd10:   a = 16'd64;
            5'd11:   a = 16'd32;
            5'd12:   a = 16'd16;
            5'd13:   a = 16'd8;
            5'd14:   a = 16'd4;
            5'd15:   a = 16'd2;
            5'd16:   a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/wtpc_ram.sv @@
module wtpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/wtpc_front.sv @@
module wtpc_front
    import wtpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [14:0] s_heading,
    input  logic               s_path_start,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        known;
    item_t       item;

    // Classify the incoming beat; unknown opcodes are dropped
    always_comb begin
        item.pos_x      = s_pos_x;
        item.pos_y      = s_pos_y;
        item.pos_z      = s_pos_z;
        item.heading    = s_heading;
        item.path_start = s_path_start;
        known           = 1'b1;
        case (s_opcode)
            OP_LOAD: item.cls = CLS_LOAD;
            OP_ODOM: item.cls = CLS_ODOM;
            OP_TICK: item.cls = CLS_TICK;
            default: begin
                item.cls = CLS_TICK;
                known    = 1'b0;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && known;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    // Two-entry queue toward the back end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (!push && q_pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

@@ rtl/core/wtpc_back.sv @@
module wtpc_back
    import wtpc_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = WAYPOINT_DEPTH_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  cfg_t               cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic signed [31:0] m_vel_z,
    output logic signed [31:0] m_yaw_rate,
    output logic               m_land,
    output logic [8:0]         m_current_target
);

    localparam int CW    = $clog2(WAYPOINT_DEPTH + 1);
    localparam int AW    = $clog2(WAYPOINT_DEPTH);
    localparam int CIW   = $clog2(CORDIC_STEPS);
    localparam int DIV_W = 63;
    localparam int CRD_W = 35;
    localparam int CZ_W  = 20;
    localparam int ERR_W = 22;
    localparam logic signed [ERR_W-1:0] PI_E     = ERR_W'(ANG_PI);
    localparam logic signed [ERR_W-1:0] TWO_PI_E = ERR_W'(ANG_TWO_PI);
    localparam logic signed [CZ_W-1:0]  HALF_Z   = CZ_W'(ANG_HALF_PI);

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_lim(input logic signed [65:0] v,
                                                     input logic [30:0] lim);
        logic signed [65:0] l;
        logic signed [65:0] r;
        l = $signed({35'd0, lim});
        if (v > l) begin
            r = l;
        end else if (v < -l) begin
            r = -l;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    back_state_t state_reg, state_next;

    // Control state
    logic [CW-1:0] pl_reg, tp_reg;
    logic          path_valid_reg, pose_valid_reg, landing_reg;
    logic          m_valid_reg;

    // Pose
    logic signed [31:0] veh_x_reg, veh_y_reg, veh_z_reg;
    logic signed [14:0] heading_reg;

    // Work registers
    kind_t               kind_reg;
    logic signed [31:0]  dx_reg, dy_reg, dz_reg;
    logic [63:0]         sq_a_reg, sq_b_reg, r2_reg;
    logic signed [31:0]  vx_reg, vy_reg, vz_reg, wr_reg;
    logic [63:0]         sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [31:0]         rem_reg;
    logic                neg_reg;
    logic [5:0]          cnt_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic signed [CZ_W-1:0]  cz_reg;
    logic [CIW-1:0]      ci_reg;
    logic signed [ERR_W-1:0] err_reg;

    // Output register
    kind_t               m_kind_reg;
    logic signed [31:0]  m_vx_reg, m_vy_reg, m_vz_reg, m_wr_reg;
    logic                m_land_reg;
    logic [8:0]          m_tgt_reg;

    // Waypoint memory
    logic          ram_we;
    logic [AW-1:0] ram_wa;
    logic [95:0]   ram_rd;

    wtpc_ram #(
        .WIDTH (96),
        .DEPTH (WAYPOINT_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data ({q_item.pos_z, q_item.pos_y, q_item.pos_x}),
        .rd_addr (tp_reg[AW-1:0]),
        .rd_data (ram_rd)
    );

    // Shared multiplier and helpers
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod, prod_sh, prod_abs;
    logic               is_tick, no_ctx, path_done, reach_hit, lim_over, slot_free;
    logic [63:0]        d_sum;
    logic signed [32:0] dz_w, dz_abs;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [DIV_W-1:0]   num_step;
    logic [31:0]        rem_step;
    logic [31:0]        quo;
    logic signed [CRD_W-1:0] xs, ys;
    logic [15:0]        atan_v;
    logic               cord_zero;

    assign prod      = mul_a * mul_b;
    assign prod_sh   = prod >>> 8;
    assign prod_abs  = prod[65] ? -prod : prod;
    assign is_tick   = q_valid && (q_item.cls == CLS_TICK);
    assign no_ctx    = !path_valid_reg || !pose_valid_reg;
    assign path_done = (tp_reg >= pl_reg);
    assign d_sum     = sq_a_reg + sq_b_reg;
    assign dz_w      = 33'(dz_reg);
    assign dz_abs    = dz_w[32] ? -dz_w : dz_w;
    assign reach_hit = (d_sum < r2_reg) && ($unsigned(dz_abs) < {2'b00, cfg.reach_z});
    assign lim_over  = d_sum > r2_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign sq_sum    = sq_r_reg + sq_bit_reg;
    assign sq_ge     = sq_n_reg >= sq_sum;
    assign div_t     = {rem_reg, num_reg[DIV_W-1]};
    assign div_ge    = div_t >= {1'b0, sq_r_reg[31:0]};
    assign rem_step  = div_ge ? 32'(div_t - {1'b0, sq_r_reg[31:0]}) : div_t[31:0];
    assign num_step  = {num_reg[DIV_W-2:0], div_ge};
    assign quo       = num_step[31:0];
    assign xs        = cx_reg >>> ci_reg;
    assign ys        = cy_reg >>> ci_reg;
    assign atan_v    = atan_lut(5'(ci_reg));
    assign cord_zero = (dx_reg == 32'sd0) && (dy_reg == 32'sd0);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_tick) begin
                    state_next = (no_ctx || path_done) ? ST_OUT : ST_RD;
                end
            end
            ST_RD:    state_next = ST_DIF;
            ST_DIF:   state_next = ST_DXX;
            ST_DXX:   state_next = ST_DYY;
            ST_DYY:   state_next = ST_RR;
            ST_RR:    state_next = ST_REACH;
            ST_REACH: state_next = reach_hit ? ST_OUT : ST_VX;
            ST_VX:    state_next = ST_VY;
            ST_VY:    state_next = ST_VZ;
            ST_VZ:    state_next = ST_VXX;
            ST_VXX:   state_next = ST_VYY;
            ST_VYY:   state_next = ST_LL;
            ST_LL:    state_next = ST_LIMT;
            ST_LIMT:  state_next = lim_over ? ST_SQRT : ST_CINIT;
            ST_SQRT:  state_next = (sq_bit_reg == 64'd1) ? ST_PX : ST_SQRT;
            ST_PX:    state_next = ST_DIVX;
            ST_DIVX:  state_next = (cnt_reg == 6'(DIV_W - 1)) ? ST_PY : ST_DIVX;
            ST_PY:    state_next = ST_DIVY;
            ST_DIVY:  state_next = (cnt_reg == 6'(DIV_W - 1)) ? ST_CINIT : ST_DIVY;
            ST_CINIT: state_next = cord_zero ? ST_ERR : ST_CORD;
            ST_CORD:  state_next = (ci_reg == CIW'(CORDIC_STEPS - 1)) ? ST_ERR : ST_CORD;
            ST_ERR:   state_next = ST_WRAP;
            ST_WRAP: begin
                if (err_reg <= PI_E && err_reg >= -PI_E) begin
                    state_next = ST_WR;
                end
            end
            ST_WR:    state_next = ST_OUT;
            ST_OUT:   state_next = slot_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: queue pop, store write, multiplier operands
    always_comb begin
        q_pop  = (state_reg == ST_IDLE) && q_valid;
        // A path start writes its first point at slot zero
        ram_we = q_pop && (q_item.cls == CLS_LOAD) &&
                 (q_item.path_start || (pl_reg < CW'(WAYPOINT_DEPTH)));
        ram_wa = q_item.path_start ? AW'(0) : pl_reg[AW-1:0];
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_DXX: begin mul_a = 33'(dx_reg); mul_b = 33'(dx_reg); end
            ST_DYY: begin mul_a = 33'(dy_reg); mul_b = 33'(dy_reg); end
            ST_RR:  begin
                mul_a = $signed({2'b00, cfg.reach_xy});
                mul_b = $signed({2'b00, cfg.reach_xy});
            end
            ST_VX:  begin mul_a = $signed({17'd0, cfg.gain_xy}); mul_b = 33'(dx_reg); end
            ST_VY:  begin mul_a = $signed({17'd0, cfg.gain_xy}); mul_b = 33'(dy_reg); end
            ST_VZ:  begin mul_a = $signed({17'd0, cfg.gain_z});  mul_b = 33'(dz_reg); end
            ST_VXX: begin mul_a = 33'(vx_reg); mul_b = 33'(vx_reg); end
            ST_VYY: begin mul_a = 33'(vy_reg); mul_b = 33'(vy_reg); end
            ST_LL:  begin
                mul_a = $signed({2'b00, cfg.lim_xy});
                mul_b = $signed({2'b00, cfg.lim_xy});
            end
            ST_PX:  begin mul_a = 33'(vx_reg); mul_b = $signed({2'b00, cfg.lim_xy}); end
            ST_PY:  begin mul_a = 33'(vy_reg); mul_b = $signed({2'b00, cfg.lim_xy}); end
            ST_WR:  begin mul_a = $signed({17'd0, cfg.gain_yaw}); mul_b = 33'(err_reg); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pl_reg         <= '0;
            tp_reg         <= '0;
            path_valid_reg <= 1'b0;
            pose_valid_reg <= 1'b0;
            landing_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Result valid: set on load of the output register, cleared when taken
            m_valid_reg <= ((state_reg == ST_OUT) && slot_free) ||
                           (m_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        case (q_item.cls)
                            CLS_LOAD: begin
                                if (q_item.path_start) begin
                                    tp_reg         <= '0;
                                    landing_reg    <= 1'b0;
                                    path_valid_reg <= 1'b1;
                                    pl_reg         <= CW'(1);
                                end else if (pl_reg < CW'(WAYPOINT_DEPTH)) begin
                                    pl_reg <= pl_reg + CW'(1);
                                end
                            end
                            CLS_ODOM: pose_valid_reg <= 1'b1;
                            CLS_TICK: begin
                                if (!no_ctx && path_done) begin
                                    landing_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_REACH: begin
                    if (reach_hit) begin
                        tp_reg <= tp_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_pop && q_item.cls == CLS_ODOM) begin
                    veh_x_reg   <= q_item.pos_x;
                    veh_y_reg   <= q_item.pos_y;
                    veh_z_reg   <= q_item.pos_z;
                    heading_reg <= q_item.heading;
                end
                kind_reg <= no_ctx ? KIND_IDLE : KIND_STOP;
            end
            ST_DIF: begin
                dx_reg <= sat32(66'($signed(ram_rd[31:0])) - 66'(veh_x_reg));
                dy_reg <= sat32(66'($signed(ram_rd[63:32])) - 66'(veh_y_reg));
                dz_reg <= sat32(66'($signed(ram_rd[95:64])) - 66'(veh_z_reg));
            end
            ST_DXX, ST_VXX: sq_a_reg <= prod[63:0];
            ST_DYY, ST_VYY: sq_b_reg <= prod[63:0];
            ST_RR,  ST_LL:  r2_reg   <= prod[63:0];
            ST_REACH: kind_reg <= KIND_ADV;
            ST_VX:    vx_reg   <= sat32(prod_sh);
            ST_VY:    vy_reg   <= sat32(prod_sh);
            ST_VZ:    vz_reg   <= clamp_lim(prod_sh, cfg.lim_z);
            ST_LIMT: begin
                sq_n_reg   <= d_sum;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            // One bit pair of the integer square root per cycle
            ST_SQRT: begin
                if (sq_ge) begin
                    sq_n_reg <= sq_n_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_PX, ST_PY: begin
                num_reg <= prod_abs[DIV_W-1:0];
                neg_reg <= prod[65];
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            // Restoring divide by the magnitude, one quotient bit per cycle
            ST_DIVX, ST_DIVY: begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1)) begin
                    if (state_reg == ST_DIVX) begin
                        vx_reg <= neg_reg ? -$signed(quo) : $signed(quo);
                    end else begin
                        vy_reg <= neg_reg ? -$signed(quo) : $signed(quo);
                    end
                end
            end
            // Quadrant fold for the vectoring CORDIC
            ST_CINIT: begin
                ci_reg <= '0;
                if (cord_zero) begin
                    cz_reg <= '0;
                end else if (dx_reg < 0) begin
                    if (dy_reg >= 0) begin
                        cx_reg <= CRD_W'(dy_reg);
                        cy_reg <= -CRD_W'(dx_reg);
                        cz_reg <= HALF_Z;
                    end else begin
                        cx_reg <= -CRD_W'(dy_reg);
                        cy_reg <= CRD_W'(dx_reg);
                        cz_reg <= -HALF_Z;
                    end
                end else begin
                    cx_reg <= CRD_W'(dx_reg);
                    cy_reg <= CRD_W'(dy_reg);
                    cz_reg <= '0;
                end
            end
            ST_CORD: begin
                ci_reg <= ci_reg + CIW'(1);
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + $signed({4'd0, atan_v});
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - $signed({4'd0, atan_v});
                end
            end
            ST_ERR: err_reg <= ERR_W'(cz_reg) - ERR_W'($signed({heading_reg, 4'b0000}));
            ST_WRAP: begin
                if (err_reg > PI_E) begin
                    err_reg <= err_reg - TWO_PI_E;
                end else if (err_reg < -PI_E) begin
                    err_reg <= err_reg + TWO_PI_E;
                end
            end
            ST_WR: begin
                wr_reg   <= clamp_lim(prod_sh, cfg.lim_yaw);
                kind_reg <= KIND_VEL;
            end
            ST_OUT: begin
                if (slot_free) begin
                    m_kind_reg <= kind_reg;
                    m_vx_reg   <= (kind_reg == KIND_VEL) ? vx_reg : 32'sd0;
                    m_vy_reg   <= (kind_reg == KIND_VEL) ? vy_reg : 32'sd0;
                    m_vz_reg   <= (kind_reg == KIND_VEL) ? vz_reg : 32'sd0;
                    m_wr_reg   <= (kind_reg == KIND_VEL) ? wr_reg : 32'sd0;
                    m_land_reg <= (kind_reg == KIND_STOP);
                    m_tgt_reg  <= 9'(tp_reg);
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_vel_x          = m_vx_reg;
    assign m_vel_y          = m_vy_reg;
    assign m_vel_z          = m_vz_reg;
    assign m_yaw_rate       = m_wr_reg;
    assign m_land           = m_land_reg;
    assign m_current_target = m_tgt_reg;

    a_zero_unless_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg != KIND_VEL |->
            m_vx_reg == 0 && m_vy_reg == 0 && m_vz_reg == 0 && m_wr_reg == 0)
        else $error("velocity nonzero on non-command result");

    a_land_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_land_reg == (m_kind_reg == KIND_STOP))
        else $error("land flag disagrees with kind");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tp_reg <= pl_reg)
        else $error("target index beyond path length");

endmodule

@@ rtl/core/waypoint_tracking_p_controller.sv @@
// Channel | Handshake          | Payload
// input   | s_valid / s_ready  | s_opcode s_pos_x s_pos_y s_pos_z s_heading s_path_start
// result  | m_valid / m_ready  | m_kind m_vel_x m_vel_y m_vel_z m_yaw_rate m_land
//         |                    | m_current_target
// config  | cfg_wr_en          | cfg_index cfg_wdata
//
// Load and odometry beats retire in idle; idle and land ticks go straight to output.
// A reached-waypoint tick reads and tests the target; a command tick also
// runs CORDIC_STEPS CORDIC steps (plus a wrap step if the yaw error needs one), and
// an over-limit XY vector is scaled (32-step square root and two 63-step divides).
// A two-beat queue lets the input side keep accepting while the back end works.
// The result register holds a beat until taken; the back end waits only then.
// Reset is synchronous; the waypoint store needs no clearing.
module waypoint_tracking_p_controller
    import wtpc_pkg::*;
#(
    parameter int WAYPOINT_DEPTH = WAYPOINT_DEPTH_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [14:0] s_heading,
    input  logic               s_path_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic signed [31:0] m_vel_z,
    output logic signed [31:0] m_yaw_rate,
    output logic               m_land,
    output logic [8:0]         m_current_target
);

    cfg_t  cfg_reg;
    logic  q_valid, q_pop;
    item_t q_item;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reach_xy <= 31'd65536;
            cfg_reg.reach_z  <= 31'd32768;
            cfg_reg.lim_xy   <= 31'd65536;
            cfg_reg.lim_z    <= 31'd32768;
            cfg_reg.lim_yaw  <= 31'd32768;
            cfg_reg.gain_xy  <= 16'd384;
            cfg_reg.gain_z   <= 16'd256;
            cfg_reg.gain_yaw <= 16'd256;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REACH_XY: cfg_reg.reach_xy <= cfg_wdata;
                REG_REACH_Z:  cfg_reg.reach_z  <= cfg_wdata;
                REG_LIM_XY:   cfg_reg.lim_xy   <= cfg_wdata;
                REG_LIM_Z:    cfg_reg.lim_z    <= cfg_wdata;
                REG_LIM_YAW:  cfg_reg.lim_yaw  <= cfg_wdata;
                REG_GAIN_XY:  cfg_reg.gain_xy  <= cfg_wdata[15:0];
                REG_GAIN_Z:   cfg_reg.gain_z   <= cfg_wdata[15:0];
                REG_GAIN_YAW: cfg_reg.gain_yaw <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    wtpc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_heading    (s_heading),
        .s_path_start (s_path_start),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    wtpc_back #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .cfg              (cfg_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_vel_x          (m_vel_x),
        .m_vel_y          (m_vel_y),
        .m_vel_z          (m_vel_z),
        .m_yaw_rate       (m_yaw_rate),
        .m_land           (m_land),
        .m_current_target (m_current_target)
    );

endmodule
